// ----- hdl/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, constants and codes of the triangle contour segment core.
// ----------------------------------------------------------------------------
package tcs_pkg;

	// default level limit and cap on segments per triangle
	localparam int MAX_LEVELS_DEF = 16;
	localparam int MAX_RESULTS    = 16;
	localparam int RES_W          = $clog2(MAX_RESULTS + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd2;

	// datapath widths
	localparam int NUM_W = 36;	// dividend magnitude
	localparam int DEN_W = 21;	// divisor (16 * |dz| at most)
	localparam int V_W   = 18;	// level height
	localparam int SPAN_W = 17;

	typedef struct packed {
		logic signed [15:0] corner_a_x;
		logic signed [15:0] corner_a_y;
		logic signed [15:0] corner_a_z;
		logic signed [15:0] corner_b_x;
		logic signed [15:0] corner_b_y;
		logic signed [15:0] corner_b_z;
		logic signed [15:0] corner_c_x;
		logic signed [15:0] corner_c_y;
		logic signed [15:0] corner_c_z;
	} tri_t;

	typedef struct packed {
		logic signed [11:0] seg_start_x;
		logic signed [11:0] seg_start_y;
		logic signed [11:0] seg_end_x;
		logic signed [11:0] seg_end_y;
		logic [3:0]         level_index;
		logic               last;
	} seg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_LVL_MUL,
		S_LVL_DIV,
		S_LVL_WAIT,
		S_LVL_TEST,
		S_INT_MUL,
		S_INT_ADD,
		S_INT_DIV,
		S_INT_WAIT,
		S_SEG,
		S_NEXT,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_tri;
		logic n_clr;
		logic n_inc;
		logic lvl_mul;
		logic div_start;
		logic div_lvl;
		logic v_load;
		logic int_mul;
		logic int_add;
		logic crd_store;
		logic edge_sel;
		logic crd_sel;
		logic pend_load;
		logic out_load;
		logic out_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic flat;
		logic count_zero;
		logic n_end;
		logic v_above;
		logic v_below;
		logic two_hits;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// ----- hdl/tcs_div.sv -----
// ----------------------------------------------------------------------------
// tcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcs_div import tcs_pkg::*; #(
	parameter int NW = NUM_W,
	parameter int DW = DEN_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          fits;

	// trial subtract of the next partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		fits    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

// ----- hdl/tcs_datapath.sv -----
// ----------------------------------------------------------------------------
// tcs_datapath
// Registers, level and interpolation arithmetic, segment and output holding.
// ----------------------------------------------------------------------------
module tcs_datapath import tcs_pkg::*; #(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  tri_t                  in_data,
	output seg_t                  out_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  cmd_t                  cmd,
	output status_t               sts
);
	localparam int LW   = $clog2(MAX_LEVELS + 1);
	localparam int PW   = SPAN_W + LW + 1;
	localparam int P1_W = 33;
	localparam int P2_W = V_W + 17;

	logic signed [15:0] min_q, max_q;
	logic [7:0]         count_q;
	tri_t               tri_q;
	logic [LW-1:0]      n_q;
	logic [LW-1:0]      cnt_sat;
	logic signed [SPAN_W-1:0] span;
	logic signed [PW-1:0]     lvl_prod_q;
	logic signed [V_W-1:0]    v_q;
	logic signed [V_W-1:0]    za, zb, zc, zmin, zmax;
	logic [2:0]               hit;
	logic [1:0]               first_e, second_e, cur_e;
	logic signed [15:0]       cp, cq, zp, zq;
	logic signed [16:0]       dz, dc;
	logic signed [16:0]       dz_q;
	logic signed [V_W-1:0]    dv;
	logic signed [P1_W-1:0]   p1_q;
	logic signed [P2_W-1:0]   p2_q;
	logic signed [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic                     div_neg, div_neg_q;
	logic                     div_done;
	logic [NUM_W-1:0]         quot;
	logic signed [NUM_W-1:0]  q_signed;
	logic signed [11:0]       sx_q, sy_q, ex_q, ey_q;
	seg_t                     pend_q, out_q;
	logic                     out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= 16'sd0;
			max_q   <= 16'sd32767;
			count_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEVEL_MIN:   min_q   <= cfg_wdata;
				REG_LEVEL_MAX:   max_q   <= cfg_wdata;
				REG_LEVEL_COUNT: count_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// triangle and level counter
	always_ff @(posedge clk) begin
		if (cmd.load_tri)
			tri_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (cmd.n_clr) begin
			n_q <= '0;
		end else if (cmd.n_inc) begin
			n_q <= n_q + 1'b1;
		end
	end

	assign cnt_sat = (count_q > 8'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(count_q);
	assign span    = SPAN_W'(max_q) - SPAN_W'(min_q);

	// corner height range
	always_comb begin
		za   = V_W'(tri_q.corner_a_z);
		zb   = V_W'(tri_q.corner_b_z);
		zc   = V_W'(tri_q.corner_c_z);
		zmin = za;
		zmax = za;
		if (zb < zmin) zmin = zb;
		if (zc < zmin) zmin = zc;
		if (zb > zmax) zmax = zb;
		if (zc > zmax) zmax = zc;
	end

	// edge crossing tests: ab, bc, ac
	function automatic logic crosses(logic signed [V_W-1:0] v,
			logic signed [V_W-1:0] z1, logic signed [V_W-1:0] z2);
		return (z1 != z2) && (((v >= z1) && (v <= z2)) || ((v <= z1) && (v >= z2)));
	endfunction

	always_comb begin
		hit[0]   = crosses(v_q, za, zb);
		hit[1]   = crosses(v_q, zb, zc);
		hit[2]   = crosses(v_q, za, zc);
		first_e  = hit[0] ? 2'd0 : 2'd1;
		second_e = (hit[0] && hit[1]) ? 2'd1 : 2'd2;
		cur_e    = cmd.edge_sel ? second_e : first_e;
	end

	// end corners of the selected edge and coordinate
	always_comb begin
		unique case (cur_e)
			2'd0: begin
				zp = tri_q.corner_a_z; zq = tri_q.corner_b_z;
				cp = cmd.crd_sel ? tri_q.corner_a_y : tri_q.corner_a_x;
				cq = cmd.crd_sel ? tri_q.corner_b_y : tri_q.corner_b_x;
			end
			2'd1: begin
				zp = tri_q.corner_b_z; zq = tri_q.corner_c_z;
				cp = cmd.crd_sel ? tri_q.corner_b_y : tri_q.corner_b_x;
				cq = cmd.crd_sel ? tri_q.corner_c_y : tri_q.corner_c_x;
			end
			default: begin
				zp = tri_q.corner_a_z; zq = tri_q.corner_c_z;
				cp = cmd.crd_sel ? tri_q.corner_a_y : tri_q.corner_a_x;
				cq = cmd.crd_sel ? tri_q.corner_c_y : tri_q.corner_c_x;
			end
		endcase
		dz = 17'(zq) - 17'(zp);
		dc = 17'(cq) - 17'(cp);
		dv = v_q - V_W'(zp);
	end

	// products and numerator
	always_ff @(posedge clk) begin
		if (cmd.lvl_mul)
			lvl_prod_q <= $signed({1'b0, n_q}) * span;
		if (cmd.int_mul) begin
			p1_q <= cp * dz;
			p2_q <= dv * dc;
			dz_q <= dz;
		end
		if (cmd.int_add)
			num_q <= NUM_W'(p1_q) + NUM_W'(p2_q);
	end

	// divider operands: magnitude in, sign applied after
	always_comb begin
		if (cmd.div_lvl) begin
			div_neg = lvl_prod_q[PW-1];
			div_num = NUM_W'(lvl_prod_q[PW-1] ? -lvl_prod_q : lvl_prod_q);
			div_den = DEN_W'(cnt_sat);
		end else begin
			div_neg = num_q[NUM_W-1] ^ dz_q[16];
			div_num = num_q[NUM_W-1] ? -num_q : num_q;
			div_den = {(dz_q[16] ? 17'(-dz_q) : 17'(dz_q)), 4'b0000};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			div_neg_q <= div_neg;
	end

	tcs_div #(
		.NW(NUM_W),
		.DW(DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	assign q_signed = div_neg_q ? -$signed(quot) : $signed(quot);

	// level height and endpoint coordinates
	always_ff @(posedge clk) begin
		if (cmd.v_load)
			v_q <= V_W'(min_q) + V_W'(q_signed);
		if (cmd.crd_store) begin
			unique case ({cmd.edge_sel, cmd.crd_sel})
				2'b00: sx_q <= q_signed[11:0];
				2'b01: sy_q <= q_signed[11:0];
				2'b10: ex_q <= q_signed[11:0];
				default: ey_q <= q_signed[11:0];
			endcase
		end
		if (cmd.pend_load) begin
			pend_q.seg_start_x <= sx_q;
			pend_q.seg_start_y <= sy_q;
			pend_q.seg_end_x   <= ex_q;
			pend_q.seg_end_y   <= ey_q;
			pend_q.level_index <= 4'(n_q);
			pend_q.last        <= 1'b0;
		end
		if (cmd.out_load) begin
			out_q.seg_start_x <= pend_q.seg_start_x;
			out_q.seg_start_y <= pend_q.seg_start_y;
			out_q.seg_end_x   <= pend_q.seg_end_x;
			out_q.seg_end_y   <= pend_q.seg_end_y;
			out_q.level_index <= pend_q.level_index;
			out_q.last        <= cmd.out_last;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	// status back to the controller
	always_comb begin
		sts.flat       = (za == zb) && (zb == zc);
		sts.count_zero = (cnt_sat == '0);
		sts.n_end      = ((LW+1)'(n_q) + 1'b1) == (LW+1)'(cnt_sat);
		sts.v_above    = v_q > zmax;
		sts.v_below    = v_q < zmin;
		sts.two_hits   = (2'(hit[0]) + 2'(hit[1]) + 2'(hit[2])) == 2'd2;
		sts.div_done   = div_done;
		sts.out_free   = !out_valid_q || out_ready;
	end
endmodule

// ----- hdl/tcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer over levels, edges and coordinates; holds one segment back
// so the final one of a triangle can be flagged.
// ----------------------------------------------------------------------------
module tcs_ctrl import tcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t sts,
	output cmd_t    cmd
);
	state_t           state_q, state_d;
	logic             e_q, crd_q;
	logic [RES_W-1:0] res_q;
	logic             pend_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_CHECK;
			S_CHECK:    state_d = (sts.flat || sts.count_zero) ? S_IDLE : S_LVL_MUL;
			S_LVL_MUL:  state_d = S_LVL_DIV;
			S_LVL_DIV:  state_d = S_LVL_WAIT;
			S_LVL_WAIT: if (sts.div_done) state_d = S_LVL_TEST;
			S_LVL_TEST: begin
				priority if (sts.v_above)
					state_d = S_FINISH;
				else if (sts.v_below || !sts.two_hits)
					state_d = S_NEXT;
				else if (res_q == RES_W'(MAX_RESULTS))
					state_d = S_FINISH;
				else
					state_d = S_INT_MUL;
			end
			S_INT_MUL:  state_d = S_INT_ADD;
			S_INT_ADD:  state_d = S_INT_DIV;
			S_INT_DIV:  state_d = S_INT_WAIT;
			S_INT_WAIT: if (sts.div_done) state_d = (e_q && crd_q) ? S_SEG : S_INT_MUL;
			S_SEG:      if (!pend_valid_q || sts.out_free) state_d = S_NEXT;
			S_NEXT:     state_d = sts.n_end ? S_FINISH : S_LVL_MUL;
			S_FINISH:   if (!pend_valid_q || sts.out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.edge_sel = e_q;
		cmd.crd_sel  = crd_q;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_tri = in_valid;
			end
			S_CHECK:    cmd.n_clr = 1'b1;
			S_LVL_MUL:  cmd.lvl_mul = 1'b1;
			S_LVL_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_lvl   = 1'b1;
			end
			S_LVL_WAIT: cmd.v_load = sts.div_done;
			S_INT_MUL:  cmd.int_mul = 1'b1;
			S_INT_ADD:  cmd.int_add = 1'b1;
			S_INT_DIV:  cmd.div_start = 1'b1;
			S_INT_WAIT: cmd.crd_store = sts.div_done;
			S_SEG: begin
				if (!pend_valid_q || sts.out_free) begin
					cmd.pend_load = 1'b1;
					cmd.out_load  = pend_valid_q;
				end
			end
			S_NEXT:     cmd.n_inc = !sts.n_end;
			S_FINISH: begin
				cmd.out_load = pend_valid_q && sts.out_free;
				cmd.out_last = 1'b1;
			end
			default: ;
		endcase
	end

	// state, edge/coordinate step, segment count, held segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			e_q          <= 1'b0;
			crd_q        <= 1'b0;
			res_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LVL_TEST) begin
				e_q   <= 1'b0;
				crd_q <= 1'b0;
			end else if (cmd.crd_store) begin
				crd_q <= !crd_q;
				if (crd_q)
					e_q <= !e_q;
			end
			if (cmd.load_tri)
				res_q <= '0;
			else if (cmd.pend_load)
				res_q <= res_q + 1'b1;
			if (cmd.pend_load)
				pend_valid_q <= 1'b1;
			else if (state_q == S_FINISH && cmd.out_load)
				pend_valid_q <= 1'b0;
		end
	end
endmodule

// ----- hdl/triangle_contour_segments_core.sv -----
// ----------------------------------------------------------------------------
// triangle_contour_segments_core
// Contour segments through one triangle for a set of evenly spaced levels.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one triangle: three corners
// with Q12.4 x, y and an integer height. Output channel (out_valid/out_ready/
// out_data) gives one segment per contour level that crosses the triangle,
// in ascending level order, with last set on the final one.
// A triangle is taken only when the core is idle. Each visited level costs a
// level division and each emitted segment four endpoint divisions on the one
// shared bit-serial divider. Triangles that are flat or meet a level count
// of zero go back to idle from the check state without any division.
// One segment is held back until the next is found, so a segment appears
// once the next segment is computed or the triangle finishes. A stalled
// receiver holds the output register; the core then waits before handing
// over the next segment. Reset empties the core and sets level_min 0,
// level_max 32767 and level_count 0. Configuration is written via cfg_we.
// ----------------------------------------------------------------------------
module triangle_contour_segments_core import tcs_pkg::*; #(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tri_t                  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output seg_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	cmd_t    cmd;
	status_t sts;

	tcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcs_datapath #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule
